// ===== sv/xbe_pkg.sv =====
// xbe_pkg: shared types, constants and the XTEA mixing function for the
// XTEA block encipher. No dependencies; imported by all xbe modules.
package xbe_pkg;

    localparam int WORD_W = 32;
    localparam int KEY_WORDS = 4;
    localparam int CFG_INDEX_W = 8;
    localparam logic [WORD_W-1:0] XBE_DELTA = 32'h9E37_79B9;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD0 = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD1 = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD2 = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD3 = 8'd3;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

    typedef struct packed {
        logic [WORD_W-1:0] block_high;
        logic [WORD_W-1:0] block_low;
    } blk_t;

    typedef struct packed {
        logic [WORD_W-1:0] cipher_high;
        logic [WORD_W-1:0] cipher_low;
    } res_t;

    typedef struct packed {
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } words_t;

    function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

endpackage

// ===== sv/xbe_stage.sv =====
// xbe_stage: one registered XTEA Feistel half-round with its sum fixed at
// elaboration. Depends on xbe_pkg.
module xbe_stage
    import xbe_pkg::*;
#(
    parameter int HALF_IDX = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  logic   valid_in,
    input  words_t data_in,
    input  key_t   key,
    output logic   valid_out,
    output words_t data_out
);

    localparam int ROUND_NUM = HALF_IDX / 2;
    localparam bit SECOND_HALF = (HALF_IDX % 2) == 1;
    localparam logic [63:0] SUM_WIDE =
        64'(ROUND_NUM + (SECOND_HALF ? 1 : 0)) * 64'(XBE_DELTA);
    localparam logic [WORD_W-1:0] SUM = SUM_WIDE[WORD_W-1:0];
    localparam logic [1:0] KEY_SEL = SECOND_HALF ? 2'(SUM >> 11) : 2'(SUM);

    logic              valid_reg;
    words_t            data_reg;
    words_t            data_next;
    logic [WORD_W-1:0] src_word;
    logic [WORD_W-1:0] round_key;
    logic [WORD_W-1:0] f_word;

    always_comb
    begin
        src_word  = SECOND_HALF ? data_in.left : data_in.right;
        round_key = SUM + key[KEY_SEL];
        f_word    = mix_word(src_word) ^ round_key;
        data_next = data_in;
        if (SECOND_HALF)
        begin
            data_next.right = data_in.right + f_word;
        end
        else
        begin
            data_next.left = data_in.left + f_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// ===== sv/xbe_out_skid.sv =====
// xbe_out_skid: output register plus one-entry skid buffer that decouples
// the round pipeline from result backpressure. Depends on xbe_pkg.
module xbe_out_skid
    import xbe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   tail_valid,
    input  words_t tail_data,
    output logic   advance,
    input  logic   res_stall,
    output logic   res_valid,
    output res_t   res_data
);

    logic   out_valid_reg;
    logic   out_valid_next;
    words_t out_data_reg;
    words_t out_data_next;
    logic   skid_valid_reg;
    logic   skid_valid_next;
    words_t skid_data_reg;
    logic   out_load;
    logic   skid_load;

    assign advance  = !skid_valid_reg;
    assign out_load = !out_valid_reg || !res_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_load       = 1'b0;
        if (skid_valid_reg)
        begin
            if (out_load)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_load)
        begin
            out_valid_next = tail_valid;
            out_data_next  = tail_data;
        end
        else if (tail_valid)
        begin
            skid_valid_next = 1'b1;
            skid_load       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (skid_load)
        begin
            skid_data_reg <= tail_data;
        end
    end

    assign res_valid            = out_valid_reg;
    assign res_data.cipher_high = out_data_reg.left;
    assign res_data.cipher_low  = out_data_reg.right;

    // skid only holds data behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid buffer full with no result on output");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && res_stall && tail_valid))
        else $error("skid buffer filled without a stalled result");

    a_stall_catch: assert property (@(posedge clk) disable iff (!rst_n)
        (!skid_valid_reg && out_valid_reg && res_stall && tail_valid) |=> skid_valid_reg)
        else $error("pipeline tail transaction dropped under stall");

endmodule

// ===== sv/xtea_block_encipher.sv =====
// XTEA block encipher: enciphers one 64-bit block per transaction under a
// 128-bit key held in four configuration words (indexes 0..3; other indexes
// are ignored). Each of the 2*ROUNDS Feistel half-rounds is one pipeline
// stage, followed by an output register, and a new block is accepted every
// cycle while blk_stall is low. A one-entry skid buffer behind the output
// register absorbs result stalls; blk_stall rises only while that buffer
// is occupied. Key words must be written only while no transaction is in
// flight. Depends on xbe_pkg, xbe_stage and xbe_out_skid.
module xtea_block_encipher
    import xbe_pkg::*;
#(
    parameter int ROUNDS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   blk_valid,
    output logic                   blk_stall,
    input  blk_t                   blk_data,
    output logic                   res_valid,
    input  logic                   res_stall,
    output res_t                   res_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data
);

    localparam int HALF_ROUNDS = 2 * ROUNDS;

    key_t   key_reg;
    logic   advance;
    logic   stage_valid [HALF_ROUNDS+1];
    words_t stage_data  [HALF_ROUNDS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_WORD0: key_reg[0] <= cfg_data;
                CFG_KEY_WORD1: key_reg[1] <= cfg_data;
                CFG_KEY_WORD2: key_reg[2] <= cfg_data;
                CFG_KEY_WORD3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign blk_stall            = !advance;
    assign stage_valid[0]       = blk_valid && advance;
    assign stage_data[0].left   = blk_data.block_high;
    assign stage_data[0].right  = blk_data.block_low;

    for (genvar g = 0; g < HALF_ROUNDS; g++)
    begin : g_half
        xbe_stage #(
            .HALF_IDX (g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (stage_valid[g]),
            .data_in   (stage_data[g]),
            .key       (key_reg),
            .valid_out (stage_valid[g+1]),
            .data_out  (stage_data[g+1])
        );
    end

    xbe_out_skid u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .tail_valid (stage_valid[HALF_ROUNDS]),
        .tail_data  (stage_data[HALF_ROUNDS]),
        .advance    (advance),
        .res_stall  (res_stall),
        .res_valid  (res_valid),
        .res_data   (res_data)
    );

    a_cfg_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_index != CFG_KEY_WORD0 && cfg_index != CFG_KEY_WORD1
            && cfg_index != CFG_KEY_WORD2 && cfg_index != CFG_KEY_WORD3)
        |=> $stable(key_reg))
        else $error("key changed by write to unmapped register");

endmodule

// ===== sim/tb_xtea_block_encipher.sv =====
// Testbench for xtea_block_encipher: random and directed blocks under several
// key settings, each result checked against an in-bench XTEA encipher model.
// Depends on xbe_pkg and the xtea_block_encipher RTL.
`timescale 1ns / 1ps

module tb_xtea_block_encipher;
    import xbe_pkg::*;

    localparam int ENC_ROUNDS = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_FIRST = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LAST = 8'hFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic blk_valid = 1'b0;
    logic blk_stall;
    blk_t blk_data = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0] cfg_data = '0;

    logic [WORD_W-1:0] key_words [KEY_WORDS];
    blk_t pending_blocks [$];
    res_t cipher_expect_q [$];
    int mismatches = 0;
    int blocks_in = 0;

    int send_gap = 0;
    bit send_calm = 1'b0;
    int recv_gap = 0;
    bit recv_calm = 1'b0;
    bit hold_on = 1'b0;
    int hold_left = 0;
    int next_hold_at = 150;
    res_t got_expect;

    xtea_block_encipher #(.ROUNDS(ENC_ROUNDS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_valid (blk_valid),
        .blk_stall (blk_stall),
        .blk_data  (blk_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [WORD_W-1:0] feistel_mix(input logic [WORD_W-1:0] w);
        return ({w[27:0], 4'b0000} ^ {5'b00000, w[31:5]}) + w;
    endfunction

    function automatic res_t encipher_model(input blk_t b);
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] acc;
        res_t r;
        v0 = b.block_high;
        v1 = b.block_low;
        acc = '0;
        for (int i = 0; i < ENC_ROUNDS; i++)
        begin
            v0 = v0 + (feistel_mix(v1) ^ (acc + key_words[acc[1:0]]));
            acc = acc + XBE_DELTA;
            v1 = v1 + (feistel_mix(v0) ^ (acc + key_words[acc[12:11]]));
        end
        r.cipher_high = v0;
        r.cipher_low = v1;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] bit1;
        bit1 = 32'd1 << $urandom_range(0, 31);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return bit1;
            3: return ~bit1;
            default: return $urandom;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [WORD_W-1:0] exp_w,
                                 input logic [WORD_W-1:0] act_w);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s expected %08h actual %08h", $realtime, what, exp_w, act_w);
    endtask

    task automatic queue_block(input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] lo);
        blk_t b;
        b.block_high = hi;
        b.block_low = lo;
        pending_blocks.insert(pending_blocks.size(), b);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            queue_block(rand_word(), rand_word());
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < KEY_WORDS)
            key_words[idx[1:0]] = val;
    endtask

    task automatic write_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                             input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
        write_cfg(CFG_KEY_WORD0, k0);
        write_cfg(CFG_KEY_WORD1, k1);
        write_cfg(CFG_KEY_WORD2, k2);
        write_cfg(CFG_KEY_WORD3, k3);
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (pending_blocks.size() != 0 || blk_valid || cipher_expect_q.size() != 0);
    endtask

    // block sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid <= 1'b0;
        end
        else
        begin
            if (blk_valid && !blk_stall)
            begin
                cipher_expect_q.insert(cipher_expect_q.size(), encipher_model(blk_data));
                blocks_in <= blocks_in + 1;
            end
            if (!blk_valid || !blk_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    blk_valid <= 1'b0;
                end
                else if (pending_blocks.size() != 0)
                begin
                    blk_valid <= 1'b1;
                    blk_data <= pending_blocks.pop_front();
                    if ($urandom_range(0, 31) == 0)
                        send_calm = !send_calm;
                    send_gap = send_calm ? 0 : $urandom_range(0, 16);
                end
                else
                begin
                    blk_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (cipher_expect_q.size() == 0)
                begin
                    note_mismatch("unexpected transaction, cipher_high", '0,
                                  res_data.cipher_high);
                end
                else
                begin
                    got_expect = cipher_expect_q.pop_front();
                    if (res_data.cipher_high !== got_expect.cipher_high)
                        note_mismatch("cipher_high", got_expect.cipher_high,
                                      res_data.cipher_high);
                    if (res_data.cipher_low !== got_expect.cipher_low)
                        note_mismatch("cipher_low", got_expect.cipher_low,
                                      res_data.cipher_low);
                end
                if ($urandom_range(0, 31) == 0)
                    recv_calm = !recv_calm;
                recv_gap = recv_calm ? 0 : $urandom_range(0, 16);
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
            end
            res_stall <= hold_on || (recv_gap > 0);
        end
    end

    // long receiver hold-off so the pipeline fills and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_on <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            hold_on <= (hold_left > 0);
        end
        else if (blocks_in >= next_hold_at && next_hold_at < 500)
        begin
            hold_left = 300;
            next_hold_at = next_hold_at + 300;
            hold_on <= 1'b1;
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < KEY_WORDS; i++)
            key_words[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset key (all zero) with edge-case blocks
        queue_block(32'h0000_0000, 32'h0000_0000);
        queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_block(32'h0000_0000, 32'hFFFF_FFFF);
        queue_block(32'hFFFF_FFFF, 32'h0000_0000);
        queue_block(32'h8000_0000, 32'h0000_0001);
        queue_block(32'h0000_0001, 32'h8000_0000);
        queue_block(32'hAAAA_AAAA, 32'h5555_5555);
        queue_block(32'h5555_5555, 32'hAAAA_AAAA);
        queue_block(32'h4142_4344, 32'h4546_4748);
        for (int i = 0; i < 8; i++)
            queue_block(32'h1 << (4 * i), 32'h8000_0000 >> (4 * i));
        queue_random(60);
        wait_idle();

        write_key('1, '1, '1, '1);
        queue_block(32'h0000_0000, 32'h0000_0000);
        queue_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_block(32'h7FFF_FFFF, 32'hFFFF_FFFE);
        queue_block(32'h0123_4567, 32'h89AB_CDEF);
        queue_random(80);
        wait_idle();

        write_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
        queue_block(32'h4142_4344, 32'h4546_4748);
        queue_random(100);
        wait_idle();

        // writes outside the key range must leave the key untouched
        write_cfg(CFG_UNUSED_FIRST, 32'hDEAD_BEEF);
        write_cfg(CFG_UNUSED_LAST, 32'hFFFF_FFFF);
        queue_random(100);
        wait_idle();

        for (int p = 0; p < 3; p++)
        begin
            write_key(rand_word(), rand_word(), rand_word(), rand_word());
            queue_random(90);
            wait_idle();
        end

        write_key('0, '0, '0, '0);
        queue_random(80);
        wait_idle();

        repeat (2 * ENC_ROUNDS + 8) @(posedge clk);
        if (mismatches == 0 && cipher_expect_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
sv/xbe_pkg.sv
sv/xbe_stage.sv
sv/xbe_out_skid.sv
sv/xtea_block_encipher.sv
sim/tb_xtea_block_encipher.sv
